FILE: src/eeb_pkg.sv
// Package for the extended Euclid / Bezout block: widths, controller
// states, the command and status bundles, and width conversion helpers.
// No dependencies.
package eeb_pkg;

  // Port field width, fixed by the interface.
  localparam int unsigned FIELD_WIDTH = 32;
  // Internal datapath width. All arithmetic wraps at this width (8 to 64).
  localparam int unsigned DATA_WIDTH  = 32;
  // Widest supported word, used to extend and truncate between widths.
  localparam int unsigned WIDE_WIDTH  = 64;
  // Divider step counter.
  localparam int unsigned CNT_WIDTH   = $clog2(DATA_WIDTH);
  localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(DATA_WIDTH - 1);

  typedef logic [DATA_WIDTH-1:0]  data_t;
  typedef logic [FIELD_WIDTH-1:0] field_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_UPD   = 4'b1000
  } eeb_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;   // take a new operand pair
    logic start_div; // set up the divider for r_prev / r
    logic div_step;  // one restoring division step
    logic update;    // advance the recurrence by one quotient
    logic load_out;  // copy the answer into the output register
  } eeb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic r_zero;    // current remainder is zero
  } eeb_sts_t;

  // Sign-extend a port field and wrap it to the data width.
  function automatic data_t to_data(field_t v);
    logic [WIDE_WIDTH-1:0] w;
    w = WIDE_WIDTH'(signed'(v));
    return w[DATA_WIDTH-1:0];
  endfunction

  // Take the low field bits of a data word, zero above the data width.
  function automatic field_t to_field(data_t v);
    logic [WIDE_WIDTH-1:0] w;
    w = WIDE_WIDTH'(v);
    return w[FIELD_WIDTH-1:0];
  endfunction

  // Magnitude of a two's complement word; the most negative value maps to
  // its unsigned magnitude.
  function automatic data_t magnitude(data_t v);
    return v[DATA_WIDTH-1] ? data_t'(-v) : v;
  endfunction

endpackage

FILE: src/eeb_in_if.sv
// Request channel carrying an operand pair.
// Depends on eeb_pkg.
interface eeb_in_if;
  import eeb_pkg::*;

  logic   valid;
  logic   ready;
  field_t a_value;
  field_t b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

FILE: src/eeb_out_if.sv
// Result channel carrying gcd and Bezout coefficients.
// Depends on eeb_pkg.
interface eeb_out_if;
  import eeb_pkg::*;

  logic   valid;
  logic   ready;
  field_t gcd_value;
  field_t coeff_a;
  field_t coeff_b;

  modport source (output valid, output gcd_value, output coeff_a, output coeff_b,
                  input ready);
  modport sink   (input valid, input gcd_value, input coeff_a, input coeff_b,
                  output ready);
endinterface

FILE: src/eeb_datapath.sv
// Datapath: recurrence registers, bit-serial restoring divider with
// Horner accumulation of q*s and q*t, and the output payload register.
// Depends on eeb_pkg.
module eeb_datapath (
  input  logic              clk_i,
  input  eeb_pkg::eeb_cmd_t cmd_i,
  output eeb_pkg::eeb_sts_t sts_o,
  input  eeb_pkg::field_t   a_value_i,
  input  eeb_pkg::field_t   b_value_i,
  output eeb_pkg::field_t   gcd_value_o,
  output eeb_pkg::field_t   coeff_a_o,
  output eeb_pkg::field_t   coeff_b_o
);
  import eeb_pkg::*;

  data_t rp_q, rp_d, r_q, r_d;
  data_t sp_q, sp_d, s_q, s_d;
  data_t tp_q, tp_d, t_q, t_d;
  data_t rem_q, rem_d, dvd_q, dvd_d, dsr_q, dsr_d;
  data_t acs_q, acs_d, act_q, act_d;
  field_t gcd_q, ca_q, cb_q;

  logic [DATA_WIDTH:0] rem_sh;
  logic [DATA_WIDTH:0] diff;
  logic                qbit;
  logic                q_neg;
  data_t               r_new, qs, qt;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DATA_WIDTH-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    qbit   = ~diff[DATA_WIDTH];
    // remainder takes the dividend sign, quotient the xor of both signs
    q_neg  = rp_q[DATA_WIDTH-1] ^ r_q[DATA_WIDTH-1];
    r_new  = rp_q[DATA_WIDTH-1] ? data_t'(-rem_q) : rem_q;
    qs     = q_neg ? data_t'(-acs_q) : acs_q;
    qt     = q_neg ? data_t'(-act_q) : act_q;
  end

  always_comb begin
    rp_d = rp_q; r_d = r_q;
    sp_d = sp_q; s_d = s_q;
    tp_d = tp_q; t_d = t_q;
    rem_d = rem_q; dvd_d = dvd_q; dsr_d = dsr_q;
    acs_d = acs_q; act_d = act_q;
    if (cmd_i.load_in) begin
      rp_d = to_data(a_value_i);
      r_d  = to_data(b_value_i);
      sp_d = data_t'(1);
      s_d  = '0;
      tp_d = '0;
      t_d  = data_t'(1);
    end
    if (cmd_i.start_div) begin
      rem_d = '0;
      dvd_d = magnitude(rp_q);
      dsr_d = magnitude(r_q);
      acs_d = '0;
      act_d = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = qbit ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
      dvd_d = dvd_q << 1;
      acs_d = (acs_q << 1) + (qbit ? s_q : '0);
      act_d = (act_q << 1) + (qbit ? t_q : '0);
    end
    if (cmd_i.update) begin
      rp_d = r_q;
      r_d  = r_new;
      sp_d = s_q;
      s_d  = sp_q - qs;
      tp_d = t_q;
      t_d  = tp_q - qt;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q <= rp_d; r_q <= r_d;
    sp_q <= sp_d; s_q <= s_d;
    tp_q <= tp_d; t_q <= t_d;
    rem_q <= rem_d; dvd_q <= dvd_d; dsr_q <= dsr_d;
    acs_q <= acs_d; act_q <= act_d;
    if (cmd_i.load_out) begin
      gcd_q <= to_field(rp_q);
      ca_q  <= to_field(sp_q);
      cb_q  <= to_field(tp_q);
    end
  end

  assign sts_o.r_zero = (r_q == '0);
  assign gcd_value_o  = gcd_q;
  assign coeff_a_o    = ca_q;
  assign coeff_b_o    = cb_q;

endmodule

FILE: src/eeb_ctrl.sv
// Controller: sequences load, divide, update and output, owns the
// handshakes and the divider step counter.
// Depends on eeb_pkg.
module eeb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  eeb_pkg::eeb_sts_t sts_i,
  output eeb_pkg::eeb_cmd_t cmd_o
);
  import eeb_pkg::*;

  eeb_state_e             state_q, state_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   slot_free;

  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.r_zero) begin
          // hold here until the output register can take the answer
          if (slot_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.start_div = 1'b1;
          cnt_d           = '0;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_WIDTH'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // an update only follows the last divider step
  a_upd_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> $past(state_q == S_DIV && cnt_q == DIV_LAST))
    else $error("update without a full division");

  // an answer is stored only when the remainder is zero and the slot is free
  a_load_out_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.r_zero && (!out_valid_q || out_ready_i))
    else $error("answer stored early or over a pending result");

  // a new result appears only out of the check state
  a_rise_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_CHECK))
    else $error("result valid raised outside the check state");
`endif

endmodule

FILE: src/extended_euclid_bezout.sv
// Top level of the extended Euclid / Bezout block.
// Depends on eeb_pkg, eeb_in_if, eeb_out_if, eeb_ctrl and eeb_datapath.
//
// Usage:
//   in_req_i carries a request of two signed operands a_value, b_value.
//   res_o returns one result per request: gcd_value and the coefficients
//   coeff_a, coeff_b with a_value*coeff_a + b_value*coeff_b = gcd_value,
//   following C truncating division signs (gcd may be negative). All
//   arithmetic wraps at eeb_pkg::DATA_WIDTH bits.
//   A request is taken only while the block is idle; one is worked on at a
//   time. Each Euclid iteration passes through the check state, DATA_WIDTH
//   steps of the bit-serial restoring divider (which also builds q*s and
//   q*t by shift-and-add) and the update state. At 32 bits a request needs
//   at most about 46 iterations. A zero b_value answers (a_value, 1, 0)
//   from the check state without any division step.
//   The result sits in an output register, so the next request is taken
//   while a result waits; if the receiver stalls, the block holds the next
//   answer in its check state until the register drains.
//   Reset (rst_ni low, asynchronous) returns the controller to idle and
//   drops any pending result.
module extended_euclid_bezout (
  input  logic      clk_i,
  input  logic      rst_ni,
  eeb_in_if.sink    in_req_i,
  eeb_out_if.source res_o
);
  import eeb_pkg::*;

  eeb_cmd_t cmd;
  eeb_sts_t sts;

  eeb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req_i.valid),
    .in_ready_o  (in_req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eeb_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .a_value_i   (in_req_i.a_value),
    .b_value_i   (in_req_i.b_value),
    .gcd_value_o (res_o.gcd_value),
    .coeff_a_o   (res_o.coeff_a),
    .coeff_b_o   (res_o.coeff_b)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for extended_euclid_bezout: directed and random operand
// requests, checked against a gcd / Bezout predictor kept in a scoreboard class.
// Depends on eeb_pkg, eeb_in_if, eeb_out_if and the extended_euclid_bezout top level.
module testbench;
  import eeb_pkg::*;

  // Random requests after the directed ones.
  localparam int unsigned RANDOM_REQS  = 400;
  // Watchdog limit for the whole run, with ample margin over the worst-case requests.
  localparam int unsigned LIMIT_CYCLES = 2_500_000;
  // Quiet time after the last result before the run ends.
  localparam int unsigned DRAIN_CYCLES = 1600;
  // Receiver hold-off: long enough for two requests to pile up behind it.
  localparam int unsigned HOLD_CYCLES  = 3500;
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned IDLE_PCT     = 17;
  // Windows (request index / result index) with no idling at all.
  localparam int unsigned SEND_QUIET_LO = 200;
  localparam int unsigned SEND_QUIET_HI = 300;
  localparam int unsigned RECV_QUIET_LO = 200;
  localparam int unsigned RECV_QUIET_HI = 300;
  localparam int unsigned MAX_REPORTS   = 100;

  localparam field_t MOST_NEG = 32'h8000_0000;
  localparam field_t MOST_POS = 32'h7fff_ffff;
  localparam field_t MINUS_ONE = 32'hffff_ffff;

  typedef struct packed {
    field_t gcd;
    field_t ca;
    field_t cb;
  } bezout_t;

  typedef struct packed {
    field_t a;
    field_t b;
  } operands_t;

  // Holds the expected answers of accepted requests, oldest first.
  class bezout_board;
    bezout_t     answers_due[$];
    int unsigned errors;
    int unsigned reports;

    function new();
      errors  = 0;
      reports = 0;
    endfunction

    function data_t abs_word(data_t v);
      return v[DATA_WIDTH-1] ? (~v + data_t'(1)) : v;
    endfunction

    // Quotient truncated toward zero; wraps for the most negative over -1.
    function data_t trunc_quot(data_t n, data_t d);
      data_t mq;
      mq = abs_word(n) / abs_word(d);
      return (n[DATA_WIDTH-1] ^ d[DATA_WIDTH-1]) ? (~mq + data_t'(1)) : mq;
    endfunction

    function bezout_t solve_bezout(field_t a, field_t b);
      data_t       r_old, r_cur, s_old, s_cur, t_old, t_cur, q, nxt;
      int unsigned steps;
      bezout_t     ans;
      // Sign-extend the port fields, then wrap at the datapath width.
      r_old = data_t'(signed'(a));
      r_cur = data_t'(signed'(b));
      s_old = data_t'(1);
      s_cur = '0;
      t_old = '0;
      t_cur = data_t'(1);
      steps = 0;
      while (r_cur != '0 && steps < 4 * DATA_WIDTH + 4) begin
        q     = trunc_quot(r_old, r_cur);
        nxt   = r_old - q * r_cur;
        r_old = r_cur;
        r_cur = nxt;
        nxt   = s_old - q * s_cur;
        s_old = s_cur;
        s_cur = nxt;
        nxt   = t_old - q * t_cur;
        t_old = t_cur;
        t_cur = nxt;
        steps++;
      end
      ans.gcd = field_t'(r_old);
      ans.ca  = field_t'(s_old);
      ans.cb  = field_t'(t_old);
      return ans;
    endfunction

    function void note_request(field_t a, field_t b);
      answers_due.push_back(solve_bezout(a, b));
    endfunction

    // Count every mismatch; cap the printout so a broken block stays readable.
    function void report(string field_name, field_t want, field_t got);
      errors++;
      if (reports < MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $time, field_name, want, got);
      reports++;
    endfunction

    function void check_result(bezout_t got);
      bezout_t want;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: gcd %h coeffs %h %h",
                 $time, got.gcd, got.ca, got.cb);
        return;
      end
      want = answers_due.pop_front();
      if (got.gcd !== want.gcd) report("gcd_value", want.gcd, got.gcd);
      if (got.ca !== want.ca)   report("coeff_a", want.ca, got.ca);
      if (got.cb !== want.cb)   report("coeff_b", want.cb, got.cb);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bit          sending_done;
  int unsigned results_seen;
  int unsigned cycle_count;
  operands_t   request_q[$];
  bezout_board board = new();

  eeb_in_if  in_req();
  eeb_out_if res();

  extended_euclid_bezout DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_req_i (in_req.sink),
    .res_o    (res.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Assert reset once, release it at a falling edge.
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic field_t rand_sign(field_t v);
    return ($urandom_range(1) != 0) ? -v : v;
  endfunction

  task automatic add_request(field_t a, field_t b);
    request_q.push_back('{a: a, b: b});
  endtask

  // Directed requests first, then the random mix.
  task automatic build_requests();
    field_t      f_lo, f_hi, f_nx, pick_val, divisor;
    field_t      extremes[5];
    int unsigned pick, k;
    extremes = '{MOST_NEG, MOST_POS, MINUS_ONE, 32'd1, 32'd0};

    // Zero second operand, both zero, zero first operand.
    add_request(32'd0, 32'd0);
    add_request(32'd5, 32'd0);
    add_request(MOST_NEG, 32'd0);
    add_request(MOST_POS, 32'd0);
    add_request(32'd0, 32'd7);
    add_request(32'd0, MOST_NEG);
    // Most negative over minus one wraps the quotient.
    add_request(MOST_NEG, MINUS_ONE);
    add_request(MOST_NEG, 32'd1);
    add_request(MOST_NEG, MOST_NEG);
    add_request(MOST_POS, MOST_NEG);
    add_request(MOST_NEG, MOST_POS);
    add_request(MOST_POS, MOST_POS);
    add_request(MINUS_ONE, MINUS_ONE);
    // Every sign combination of one pair.
    add_request(32'd240, 32'd46);
    add_request(-32'd240, 32'd46);
    add_request(32'd240, -32'd46);
    add_request(-32'd240, -32'd46);
    // Largest consecutive Fibonacci numbers: the longest iteration chain.
    add_request(32'd1836311903, 32'd1134903170);
    add_request(-32'd1836311903, 32'd1134903170);
    add_request(32'd17, 32'd1);
    add_request(32'd1, 32'd17);
    add_request(32'd12345, MINUS_ONE);
    add_request(32'haaaa_aaaa, 32'h5555_5555);
    add_request(32'h5555_5555, 32'haaaa_aaaa);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        add_request(field_t'($urandom), field_t'($urandom));
      end else if (pick < 65) begin
        add_request(rand_sign($urandom_range(200)), rand_sign($urandom_range(1, 200)));
      end else if (pick < 73) begin
        if ($urandom_range(1) != 0) add_request(field_t'($urandom), '0);
        else add_request('0, field_t'($urandom));
      end else if (pick < 85) begin
        // Consecutive Fibonacci pair of random depth, random signs.
        k    = $urandom_range(2, 45);
        f_lo = 32'd1;
        f_hi = 32'd1;
        for (int j = 2; j < k; j++) begin
          f_nx = f_lo + f_hi;
          f_lo = f_hi;
          f_hi = f_nx;
        end
        add_request(rand_sign(f_hi), rand_sign(f_lo));
      end else if (pick < 93) begin
        pick_val = extremes[$urandom_range(4)];
        if ($urandom_range(1) != 0) add_request(pick_val, field_t'($urandom));
        else add_request(field_t'($urandom), pick_val);
      end else begin
        // Exact multiples: the first division leaves no remainder.
        divisor = rand_sign($urandom_range(1, 65535));
        add_request(divisor * field_t'($urandom_range(30000)), divisor);
      end
    end
  endtask

  // Request side: drive at the falling edge, hold until the block takes it.
  initial begin : drive_requests
    int unsigned idx;
    in_req.valid   = 1'b0;
    in_req.a_value = '0;
    in_req.b_value = '0;
    build_requests();
    @(posedge rst_n);
    idx = 0;
    while (idx < request_q.size()) begin
      @(negedge clk);
      if (!(idx >= SEND_QUIET_LO && idx < SEND_QUIET_HI) &&
          $urandom_range(99) < IDLE_PCT) begin
        in_req.valid <= 1'b0;
      end else begin
        in_req.valid   <= 1'b1;
        in_req.a_value <= request_q[idx].a;
        in_req.b_value <= request_q[idx].b;
        @(posedge clk);
        while (!in_req.ready) @(posedge clk);
        board.note_request(request_q[idx].a, request_q[idx].b);
        idx++;
      end
    end
    @(negedge clk);
    in_req.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side: random stalls, one quiet window, and one long hold-off so
  // the output register fills and the block stops taking requests.
  initial begin : drive_ready
    int unsigned hold_left;
    bit          hold_done;
    res.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (results_seen >= RECV_QUIET_LO && results_seen < RECV_QUIET_HI) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Sample accepted results at the rising edge.
  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready) begin
      board.check_result('{gcd: res.gcd_value, ca: res.coeff_a, cb: res.coeff_b});
      results_seen++;
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Drain: wait for every answer, then watch for stray results a while.
  initial begin : finish_run
    @(posedge rst_n);
    wait (sending_done);
    while (board.answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.answers_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
